/* sv/box_circle_overlap_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the box-circle overlap core
// Shared concurrent assertion forms with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef BOX_CIRCLE_OVERLAP_CORE_ASSERT_SVH
`define BOX_CIRCLE_OVERLAP_CORE_ASSERT_SVH

// Property checked only while reset is released.
`define BCOV_ASSERT(lbl, clk_i, rst_n_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) prop) else $error(msg);

// Property checked at every edge, reset included.
`define BCOV_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* sv/bcov_pkg.sv */
// ----------------------------------------------------------------------------
// Box-circle overlap package
// Field widths, arithmetic widths and the shared pipeline sideband types.
// ----------------------------------------------------------------------------
package bcov_pkg;

	localparam int COORD_BITS_DEF = 24;

	localparam int SIZE_W = 22;               // radius, width, height
	localparam int PUSH_W = 23;               // push_x, push_y
	localparam int MAG_W  = 25;               // doubled-scale offset magnitude
	localparam int SUM_W  = 2 * MAG_W;        // sum of squares
	localparam int ROOT_W = MAG_W;            // floor square root of the sum
	localparam int REM_W  = ROOT_W + 3;       // square root partial remainder
	localparam int DIST_W = ROOT_W - 1;       // distance in input units
	localparam int DEN_W  = ROOT_W;           // twice the distance
	localparam int Q_W    = SIZE_W;           // quotient bits below saturation
	localparam int PROD_W = DEN_W + Q_W;      // offset magnitude times gap

	localparam logic [PUSH_W-1:0] PUSH_MAX = PUSH_W'(23'h3FFFFF);
	localparam logic [MAG_W-1:0]  FAR_LIM  = MAG_W'(25'h1000000);

	typedef struct packed {
		logic [MAG_W-1:0]  mag_x;
		logic [MAG_W-1:0]  mag_y;
		logic              neg_x;
		logic              neg_y;
		logic              far;
		logic [SIZE_W-1:0] r;
	} geo_side_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [SUM_W-1:0]  sum;
		geo_side_t         side;
	} sqrt_stage_t;

	typedef struct packed {
		logic              hit;
		logic              dz;
		logic              neg_x;
		logic              neg_y;
		logic [SIZE_W-1:0] r;
	} push_side_t;

endpackage

/* sv/bcov_if.sv */
// ----------------------------------------------------------------------------
// Box-circle overlap channels
// Valid/ready channels for box-circle pairs and overlap results.
// ----------------------------------------------------------------------------
interface bcov_in_if #(
	parameter int CW = bcov_pkg::COORD_BITS_DEF
);
	import bcov_pkg::*;

	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] circle_x;
	logic signed [CW-1:0] circle_y;
	logic [SIZE_W-1:0]    radius;
	logic signed [CW-1:0] box_x;
	logic signed [CW-1:0] box_y;
	logic [SIZE_W-1:0]    box_width;
	logic [SIZE_W-1:0]    box_height;

	modport source (
		output valid, circle_x, circle_y, radius, box_x, box_y, box_width, box_height,
		input  ready
	);
	modport sink (
		input  valid, circle_x, circle_y, radius, box_x, box_y, box_width, box_height,
		output ready
	);
endinterface

interface bcov_out_if;
	import bcov_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     hit;
	logic signed [PUSH_W-1:0] push_x;
	logic signed [PUSH_W-1:0] push_y;

	modport source (
		output valid, hit, push_x, push_y,
		input  ready
	);
	modport sink (
		input  valid, hit, push_x, push_y,
		output ready
	);
endinterface

/* sv/bcov_div.sv */
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage with an up-front saturation test.
// ----------------------------------------------------------------------------
module bcov_div
	import bcov_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [PROD_W-1:0] num,
	input  logic [DEN_W-1:0]  den,
	output logic [Q_W-1:0]    quot,
	output logic              ovf
);

`include "box_circle_overlap_core_assert.svh"

	typedef struct packed {
		logic [DEN_W:0]   rem;
		logic [Q_W-1:0]   lq;    // unused dividend bits on top, quotient bits below
		logic [DEN_W-1:0] den;
		logic             ovf;
	} div_stage_t;

	div_stage_t div_s [Q_W+1];

	// The quotient reaches 2^Q_W exactly when the upper dividend part is
	// at least the divisor; below that the upper part seeds the remainder.
	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].rem <= {1'b0, num[PROD_W-1:Q_W]};
			div_s[0].lq  <= num[Q_W-1:0];
			div_s[0].den <= den;
			div_s[0].ovf <= (num[PROD_W-1:Q_W] >= den);
		end
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_step
		logic [DEN_W:0] rem_sh;
		logic           take;

		always_comb begin
			rem_sh = {div_s[k-1].rem[DEN_W-1:0], div_s[k-1].lq[Q_W-1]};
			take   = (rem_sh >= {1'b0, div_s[k-1].den});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k].rem <= take ? (rem_sh - {1'b0, div_s[k-1].den}) : rem_sh;
				div_s[k].lq  <= {div_s[k-1].lq[Q_W-2:0], take};
				div_s[k].den <= div_s[k-1].den;
				div_s[k].ovf <= div_s[k-1].ovf;
			end
		end
	end

	assign quot = div_s[Q_W].lq;
	assign ovf  = div_s[Q_W].ovf;

	// The remainder stays below the divisor whenever no saturation was seen.
	`BCOV_ASSERT(a_div_rem_bound, clk, arst_n,
		en && !div_s[Q_W].ovf && (div_s[Q_W].den != '0) |->
		(div_s[Q_W].rem < {1'b0, div_s[Q_W].den}),
		"divider remainder out of range")

endmodule

/* sv/box_circle_overlap_core.sv */
// ----------------------------------------------------------------------------
// Box-circle overlap core
// Clamps a circle centre onto an axis-aligned box and returns the hit flag
// and the push vector of length (radius - distance).
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake    Carries
//  pair      sink       valid/ready  circle_x, circle_y, radius, box_x, box_y,
//                                    box_width, box_height
//  result    source     valid/ready  hit, push_x, push_y
//
// One pair enters every cycle while the pipeline is not held; each pair passes
// through offsets, magnitudes, squares, sum, 25 square root stages, gap,
// products, 23 divider stages and the output register.
// The whole pipeline advances together: it holds only while the output
// register is full and the result side is not ready, so nothing is lost.
// Reset clears the valid bits alone; data registers hold no reset value.
//
module box_circle_overlap_core
	import bcov_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
)(
	input  logic          clk,
	input  logic          arst_n,
	bcov_in_if.sink       pair,
	bcov_out_if.source    result
);

`include "box_circle_overlap_core_assert.svh"

	localparam int CW      = COORD_BITS;
	// Wide enough for doubled coordinates plus or minus a full box size.
	localparam int OW      = ((CW > SIZE_W + 1) ? CW : SIZE_W + 1) + 3;
	localparam int DIV_LAT = Q_W + 1;
	localparam int NSTG    = 7 + ROOT_W + DIV_LAT;

	// Doubled-scale offset from the clamped point to the centre on one axis.
	function automatic logic signed [OW-1:0] axis_off(
		input logic signed [CW-1:0] c,
		input logic signed [CW-1:0] b,
		input logic [SIZE_W-1:0]    sz
	);
		logic signed [OW-1:0] c2, lo, hi, t, szs;
		szs = $signed({{(OW-SIZE_W){1'b0}}, sz});
		c2  = OW'(c) <<< 1;
		lo  = (OW'(b) <<< 1) - szs;
		hi  = (OW'(b) <<< 1) + szs;
		t   = c2;
		if (c2 < lo)
			t = lo;
		else if (c2 > hi)
			t = hi;
		return c2 - t;
	endfunction

	// Global advance: every stage moves when the output register can move.
	logic            en;
	logic [NSTG-1:0] vld_q;

	assign en          = !vld_q[NSTG-1] || result.ready;
	assign pair.ready  = en;
	assign result.valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-2:0], pair.valid};
		end
	end

	// Stage 1: clamp and offset on both axes.
	logic signed [OW-1:0] ox_s1, oy_s1;
	logic [SIZE_W-1:0]    r_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ox_s1 <= axis_off(pair.circle_x, pair.box_x, pair.box_width);
			oy_s1 <= axis_off(pair.circle_y, pair.box_y, pair.box_height);
			r_s1  <= pair.radius;
		end
	end

	// Stage 2: far test and magnitudes. A far pair cannot hit, so its
	// truncated magnitudes are never used for the answer.
	geo_side_t            geo_s2;
	logic signed [OW-1:0] fl_pos, fl_neg;
	logic [OW-1:0]        ax, ay;

	always_comb begin
		fl_pos = $signed({{(OW-MAG_W){1'b0}}, FAR_LIM});
		fl_neg = -fl_pos;
		ax     = ox_s1[OW-1] ? OW'(-ox_s1) : OW'(ox_s1);
		ay     = oy_s1[OW-1] ? OW'(-oy_s1) : OW'(oy_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s2.mag_x <= ax[MAG_W-1:0];
			geo_s2.mag_y <= ay[MAG_W-1:0];
			geo_s2.neg_x <= ox_s1[OW-1];
			geo_s2.neg_y <= oy_s1[OW-1];
			geo_s2.far   <= (ox_s1 > fl_pos) || (ox_s1 < fl_neg) ||
				(oy_s1 > fl_pos) || (oy_s1 < fl_neg);
			geo_s2.r     <= r_s1;
		end
	end

	// Stage 3: squares. Stage 4: their sum, which seeds the square root.
	logic [SUM_W-1:0] sqx_s3, sqy_s3;
	geo_side_t        geo_s3;
	sqrt_stage_t      sqp_s [ROOT_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s3         <= SUM_W'(geo_s2.mag_x * geo_s2.mag_x);
			sqy_s3         <= SUM_W'(geo_s2.mag_y * geo_s2.mag_y);
			geo_s3         <= geo_s2;
			sqp_s[0].rem   <= '0;
			sqp_s[0].root  <= '0;
			sqp_s[0].sum   <= sqx_s3 + sqy_s3;
			sqp_s[0].side  <= geo_s3;
		end
	end

	// Square root: one result bit per stage, two sum bits brought down
	// each time, most significant pair first.
	for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
		localparam int I = ROOT_W - k;
		logic [REM_W-1:0] rem_sh, trial;
		logic             take;

		always_comb begin
			rem_sh = {sqp_s[k-1].rem[REM_W-3:0], sqp_s[k-1].sum[2*I+1 -: 2]};
			trial  = REM_W'({sqp_s[k-1].root, 2'b01});
			take   = (rem_sh >= trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sqp_s[k].rem  <= take ? (rem_sh - trial) : rem_sh;
				sqp_s[k].root <= {sqp_s[k-1].root[ROOT_W-2:0], take};
				sqp_s[k].sum  <= sqp_s[k-1].sum;
				sqp_s[k].side <= sqp_s[k-1].side;
			end
		end
	end

	// Stage 5: distance against radius, gap and divisor.
	logic [DIST_W-1:0] dist_v;
	logic [DEN_W-1:0]  den_s5;
	logic [SIZE_W-1:0] gap_s5;
	logic [MAG_W-1:0]  magx_s5, magy_s5;
	push_side_t        ps_s5;

	assign dist_v = sqp_s[ROOT_W].root[ROOT_W-1:1];

	always_ff @(posedge clk) begin
		if (en) begin
			den_s5      <= {sqp_s[ROOT_W].root[ROOT_W-1:1], 1'b0};
			gap_s5      <= sqp_s[ROOT_W].side.r - dist_v[SIZE_W-1:0];
			magx_s5     <= sqp_s[ROOT_W].side.mag_x;
			magy_s5     <= sqp_s[ROOT_W].side.mag_y;
			ps_s5.hit   <= !sqp_s[ROOT_W].side.far &&
				(dist_v <= DIST_W'(sqp_s[ROOT_W].side.r));
			ps_s5.dz    <= (dist_v == '0);
			ps_s5.neg_x <= sqp_s[ROOT_W].side.neg_x;
			ps_s5.neg_y <= sqp_s[ROOT_W].side.neg_y;
			ps_s5.r     <= sqp_s[ROOT_W].side.r;
		end
	end

	// Stage 6: offset magnitude times gap on both axes.
	logic [PROD_W-1:0] prx_s6, pry_s6;
	logic [DEN_W-1:0]  den_s6;
	push_side_t        ps_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			prx_s6 <= PROD_W'(magx_s5 * gap_s5);
			pry_s6 <= PROD_W'(magy_s5 * gap_s5);
			den_s6 <= den_s5;
			ps_s6  <= ps_s5;
		end
	end

	// Divider lanes, with the push sideband delayed alongside.
	logic [Q_W-1:0] qx, qy;
	logic           ovx, ovy;
	push_side_t     psd_s [DIV_LAT];

	bcov_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.num    (prx_s6),
		.den    (den_s6),
		.quot   (qx),
		.ovf    (ovx)
	);

	bcov_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.num    (pry_s6),
		.den    (den_s6),
		.quot   (qy),
		.ovf    (ovy)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			psd_s[0] <= ps_s6;
			for (int j = 1; j < DIV_LAT; j++) begin
				psd_s[j] <= psd_s[j-1];
			end
		end
	end

	// Output register: saturate, apply signs, then the zero-distance and
	// miss cases override.
	logic [PUSH_W-1:0] magpx, magpy, px, py;
	push_side_t        pso;
	logic              hit_q;
	logic [PUSH_W-1:0] px_q, py_q;

	always_comb begin
		pso   = psd_s[DIV_LAT-1];
		magpx = ovx ? PUSH_MAX : {1'b0, qx};
		magpy = ovy ? PUSH_MAX : {1'b0, qy};
		px    = pso.neg_x ? (~magpx + 1'b1) : magpx;
		py    = pso.neg_y ? (~magpy + 1'b1) : magpy;
		if (!pso.hit) begin
			px = '0;
			py = '0;
		end else if (pso.dz) begin
			px = PUSH_W'(pso.r);
			py = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= pso.hit;
			px_q  <= px;
			py_q  <= py;
		end
	end

	assign result.hit    = hit_q;
	assign result.push_x = $signed(px_q);
	assign result.push_y = $signed(py_q);

	`BCOV_ASSERT_ALWAYS(a_ready_rule, clk,
		pair.ready === (!result.valid || result.ready),
		"input ready does not follow the output register")
	`BCOV_ASSERT(a_miss_zero, clk, arst_n,
		result.valid && !result.hit |-> (result.push_x == '0) && (result.push_y == '0),
		"miss carries a nonzero push")
	`BCOV_ASSERT(a_entry_valid, clk, arst_n,
		pair.valid && pair.ready |=> vld_q[0],
		"accepted item lost at pipeline entry")

endmodule

/* test/box_circle_overlap_core_tb.sv */
// ----------------------------------------------------------------------------
// Box-circle overlap core testbench
// Streams box-circle pairs through the core and checks every hit flag and
// push vector against an in-bench model of the clamp, square root and scaling.
// ----------------------------------------------------------------------------
module box_circle_overlap_core_tb;
	import bcov_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 24;
	localparam int PIPE_LAT = 56;
	localparam longint CYCLE_LIMIT = 400000;

	// One pair as driven onto the pair channel.
	typedef struct {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic [SIZE_W-1:0]    r;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by;
		logic [SIZE_W-1:0]    w;
		logic [SIZE_W-1:0]    h;
	} pair_t;

	// One overlap result as seen on the result channel.
	typedef struct {
		logic              hit;
		logic [PUSH_W-1:0] px;
		logic [PUSH_W-1:0] py;
	} overlap_t;

	// A row of the directed table; known says the typed-in result is checked too.
	typedef struct {
		pair_t    p;
		bit       known;
		overlap_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	longint cycles = 0;
	int errors = 0;
	int sent = 0;
	int got = 0;
	int hits = 0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	overlap_t overlap_q[$];

	bcov_in_if #(.CW(CW)) pair_ch ();
	bcov_out_if result_ch ();

	box_circle_overlap_core #(.COORD_BITS(CW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pair(pair_ch.sink),
		.result(result_ch.source)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Doubled-scale offset from the nearest box point to the circle centre.
	function automatic longint clamp_offset(longint c, longint b, longint size);
		longint c2, lo, hi;
		c2 = c * 2;
		lo = b * 2 - size;
		hi = b * 2 + size;
		if (c2 < lo) return c2 - lo;
		if (c2 > hi) return c2 - hi;
		return 0;
	endfunction

	// Floor square root, one bit pair at a time.
	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Offset scaled by gap / (2 * distance), truncated toward zero and saturated.
	function automatic logic [PUSH_W-1:0] push_component(longint o, longint unsigned gap,
			longint unsigned dist_u);
		longint unsigned mag, q;
		mag = (o < 0) ? -o : o;
		q = (mag * gap) / (2 * dist_u);
		if (q > 64'd4194303) q = 64'd4194303;
		if (o < 0) q = -q;
		return q[PUSH_W-1:0];
	endfunction

	function automatic overlap_t predict_overlap(pair_t p);
		overlap_t o;
		longint ox, oy;
		longint unsigned sum, dist_u;
		o = '{1'b0, '0, '0};
		ox = clamp_offset(longint'(p.cx), longint'(p.bx), longint'(p.w));
		oy = clamp_offset(longint'(p.cy), longint'(p.by), longint'(p.h));
		// Beyond this offset no radius in range can reach the box.
		if (ox > 16777216 || ox < -16777216 || oy > 16777216 || oy < -16777216)
			return o;
		sum = ox * ox + oy * oy;
		dist_u = floor_sqrt(sum) >> 1;
		if (dist_u > p.r) return o;
		o.hit = 1'b1;
		if (dist_u == 0) begin
			// Distance rounds down to zero: push is (radius, 0).
			o.px = PUSH_W'(p.r);
			return o;
		end
		o.px = push_component(ox, p.r - dist_u, dist_u);
		o.py = push_component(oy, p.r - dist_u, dist_u);
		return o;
	endfunction

	// Random pair; most land near the box so that hits and near misses are common.
	function automatic pair_t random_pair();
		pair_t p;
		int mode;
		mode = $urandom_range(0, 9);
		p.bx = CW'($urandom);
		p.by = CW'($urandom);
		p.w = SIZE_W'($urandom);
		p.h = SIZE_W'($urandom);
		p.r = SIZE_W'($urandom);
		p.cx = CW'($urandom);
		p.cy = CW'($urandom);
		if (mode < 7) begin
			// Small sizes and a centre within a few radii of the box.
			p.w = SIZE_W'($urandom_range(0, 1 << (2 * $urandom_range(1, 10))));
			p.h = SIZE_W'($urandom_range(0, 1 << (2 * $urandom_range(1, 10))));
			p.r = SIZE_W'($urandom_range(0, 1 << (2 * $urandom_range(0, 10))));
			p.cx = p.bx + CW'($signed($urandom_range(0, 2 * (p.w + 2 * p.r + 4)))
				- $signed(p.w + 2 * p.r + 4));
			p.cy = p.by + CW'($signed($urandom_range(0, 2 * (p.h + 2 * p.r + 4)))
				- $signed(p.h + 2 * p.r + 4));
		end else if (mode == 7) begin
			// Large radius against a nearby point box.
			p.w = 0;
			p.h = 0;
			p.cx = p.bx + CW'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
			p.cy = p.by + CW'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
		end
		return p;
	endfunction

	// Drive one pair and hold it until the core takes it. Valid stays high
	// after the handshake so that the next pair can follow without a gap.
	task automatic send_pair(pair_t p);
		while (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
			pair_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pair_ch.circle_x <= p.cx;
		pair_ch.circle_y <= p.cy;
		pair_ch.radius <= p.r;
		pair_ch.box_x <= p.bx;
		pair_ch.box_y <= p.by;
		pair_ch.box_width <= p.w;
		pair_ch.box_height <= p.h;
		pair_ch.valid <= 1'b1;
		@(posedge clk);
		while (!pair_ch.ready) @(posedge clk);
		overlap_q.push_back(predict_overlap(p));
		sent++;
		@(negedge clk);
	endtask

	// Stop sending and wait until every expected result has come back.
	task automatic drain_results();
		pair_ch.valid <= 1'b0;
		while (overlap_q.size() != 0) @(negedge clk);
	endtask

	// Result side: random stalls and comparison against the oldest expectation.
	always @(negedge clk)
		result_ch.ready <= !(snk_stall_pct != 0 && $urandom_range(1, 100) <= snk_stall_pct);

	always @(posedge clk) begin
		overlap_t exp_o;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("box_circle_overlap_core_tb NOT OK");
			$finish;
		end
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got++;
			if (overlap_q.size() == 0) begin
				$error("result item with no pair outstanding");
				errors++;
			end else begin
				exp_o = overlap_q.pop_front();
				if (result_ch.hit !== exp_o.hit) begin
					$error("hit: expected %0b, got %0b", exp_o.hit, result_ch.hit);
					errors++;
				end
				if (result_ch.push_x !== exp_o.px) begin
					$error("push_x: expected %0d, got %0d", $signed(exp_o.px),
						result_ch.push_x);
					errors++;
				end
				if (result_ch.push_y !== exp_o.py) begin
					$error("push_y: expected %0d, got %0d", $signed(exp_o.py),
						result_ch.push_y);
					errors++;
				end
				if (exp_o.hit) hits++;
			end
		end
	end

	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [SIZE_W-1:0] SMAX = '1;

	row_t dir_rows[$];

	initial begin
		pair_t p;
		pair_ch.valid = 1'b0;
		pair_ch.circle_x = '0;
		pair_ch.circle_y = '0;
		pair_ch.radius = '0;
		pair_ch.box_x = '0;
		pair_ch.box_y = '0;
		pair_ch.box_width = '0;
		pair_ch.box_height = '0;
		result_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table: zero distance, far offsets, extremes, saturation, signs.
		dir_rows = '{
			'{'{0, 0, 0, 0, 0, 0, 0}, 1, '{1, 0, 0}},
			'{'{0, 0, SMAX, 0, 0, 0, 0}, 1, '{1, 23'(SMAX), 0}},
			'{'{10, 10, 5, 0, 0, 100, 100}, 1, '{1, 5, 0}},
			'{'{CMAX, CMAX, SMAX, CMIN, CMIN, 0, 0}, 1, '{0, 0, 0}},
			'{'{CMIN, CMIN, SMAX, CMAX, CMAX, 0, 0}, 1, '{0, 0, 0}},
			'{'{CMAX, 0, SMAX, CMIN, 0, SMAX, SMAX}, 1, '{0, 0, 0}},
			'{'{CMIN, CMAX, SMAX, CMIN, CMAX, SMAX, SMAX}, 1, '{1, 23'(SMAX), 0}},
			'{'{CMAX, CMIN, 0, CMAX, CMIN, 0, 0}, 1, '{1, 0, 0}},
			'{'{1, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0}},
			'{'{2, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0}},
			'{'{3, 0, SMAX, 0, 0, 0, 0}, 0, '{0, 0, 0}},
			'{'{-3, 0, SMAX, 0, 0, 0, 0}, 0, '{0, 0, 0}},
			'{'{0, 3, SMAX, 0, 0, 0, 0}, 0, '{0, 0, 0}},
			'{'{0, -3, SMAX, 0, 0, 0, 0}, 0, '{0, 0, 0}},
			'{'{-2, -2, SMAX, 0, 0, 1, 1}, 0, '{0, 0, 0}},
			'{'{1000, -700, 1300, 0, 0, 0, 0}, 0, '{0, 0, 0}},
			'{'{1000, -700, 1200, 0, 0, 0, 0}, 0, '{0, 0, 0}},
			'{'{5000, 5000, 100, 0, 0, 2000, 2000}, 0, '{0, 0, 0}},
			'{'{1 << 22, 0, SMAX, 0, 0, 0, 0}, 0, '{0, 0, 0}},
			'{'{(1 << 22) - 1, 1, SMAX, 0, 0, 0, 0}, 0, '{0, 0, 0}},
			'{'{(1 << 23) - 1, 0, SMAX, 0, 0, SMAX, 0}, 0, '{0, 0, 0}},
			'{'{-(1 << 23), 0, SMAX, 0, 0, SMAX, 0}, 0, '{0, 0, 0}}
		};
		foreach (dir_rows[i]) begin
			send_pair(dir_rows[i].p);
			// Typed-in results are compared with the prediction only as a cross-check.
			if (dir_rows[i].known && overlap_q[$] != dir_rows[i].res) begin
				$error("row %0d: table result differs from prediction", i);
				errors++;
			end
		end
		drain_results();

		// Random phases with different idling mixes.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0; snk_stall_pct = 0; end
				1: begin src_idle_pct = 53; snk_stall_pct = 0; end
				2: begin src_idle_pct = 0; snk_stall_pct = 53; end
				default: begin src_idle_pct = 14; snk_stall_pct = 14; end
			endcase
			for (int n = 0; n < 285; n++) begin
				p = random_pair();
				send_pair(p);
				// Once per phase, hold the pair side until the pipeline is empty.
				if (n == 140) drain_results();
			end
		end
		drain_results();
		repeat (PIPE_LAT + 10) @(posedge clk);

		$display("Sent %0d pairs over four idling mixes; %0d results checked, %0d hits.",
			sent, got, hits);
		if (errors == 0 && overlap_q.size() == 0)
			$display("box_circle_overlap_core_tb OK");
		else
			$display("box_circle_overlap_core_tb NOT OK");
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/bcov_pkg.sv
sv/bcov_if.sv
sv/bcov_div.sv
sv/box_circle_overlap_core.sv
test/box_circle_overlap_core_tb.sv
